/* hw/rtl/ljgp_pkg.sv */
// ----------------------------------------------------------------------------
// ljgp_pkg
// Shared types and constants of the grid Lennard-Jones potential core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ljgp_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CUTOFF    = 3'd0;
    localparam logic [2:0] REG_SIGMA     = 3'd1;
    localparam logic [2:0] REG_STRENGTH  = 3'd2;
    localparam logic [2:0] REG_SPACING_X = 3'd3;
    localparam logic [2:0] REG_SPACING_Y = 3'd4;
    localparam logic [2:0] REG_SPACING_Z = 3'd5;

    // Grid points per axis; larger indexes clamp to the last point
    localparam int GRID_SIZE = 1024;

    // sigma^2/r^2 ratio cap (20.0 in Q.16) and cube cap (7812.5 in Q.48)
    localparam logic [20:0] U_CAP = 21'd1310720;
    localparam logic [62:0] Q_MAX = 63'd2199023255552000000;

    // Limits of a stored cutoff shift (signed 48 bits)
    localparam logic signed [58:0] SHIFT_HI = 59'sd140737488355327;
    localparam logic signed [58:0] SHIFT_LO = -59'sd140737488355328;

    localparam logic [4:0] DIV_STEPS = 5'd21;
    localparam logic [4:0] ISQ_STEPS = 5'd20;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD_SIG,
        ST_LD_ISQ,
        ST_LD_STR,
        ST_Q_RD,
        ST_Q_DIST,
        ST_Q_SQ,
        ST_Q_SUM,
        ST_T_START,
        ST_T_DIV,
        ST_T_U2,
        ST_T_U3,
        ST_T_Q,
        ST_T_QQ,
        ST_T_Q2,
        ST_T_DIFF,
        ST_T_ST,
        ST_T_TERM,
        ST_T_END,
        ST_OUT
    } ljgp_state_t;

    // One atom table entry
    typedef struct packed {
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        z;
        logic [31:0]        sigma_sq;
        logic [31:0]        strength;
        logic signed [47:0] shift;
    } ljgp_entry_t;

endpackage

/* hw/rtl/lennard_jones_grid_potential_core.sv */
// ----------------------------------------------------------------------------
// lennard_jones_grid_potential_core
// Shifted 12-6 Lennard-Jones potential of stored solute atoms on a grid.
//
// A query reads each stored atom in turn; an atom inside the cutoff also runs
//   the pair term, with the 21-step ratio divider unless the ratio is capped.
// A load runs a 20-step square root, then the shift term; a clear or a dropped
//   load starts no further work. One item is in work at a time.
// Reset: aresetn is synchronous, active low; it empties the atom table,
//   clears the overflow flag and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lennard_jones_grid_potential_core
    import ljgp_pkg::*;
#(
    parameter int MAX_ATOMS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    // atom_x, atom_y, atom_z, atom_sigma, atom_epsilon, point_ix, point_iy,
    // point_iz (lowest bits first), zero filled to 176 bits
    input  logic [175:0] s_tdata,
    // kind
    input  logic [1:0]   s_tuser,
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    // energy
    output logic [63:0]  m_tdata,
    // saturated, table_overflow (lowest bit first)
    output logic [1:0]   m_tuser,
    // register writes
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW = $clog2(MAX_ATOMS + 1);

    // ------------------------------------------------------------------
    // Input fields
    // ------------------------------------------------------------------
    logic [31:0] in_x, in_y, in_z;
    logic [23:0] in_sigma, in_eps;
    logic [9:0]  in_ix, in_iy, in_iz;
    logic [1:0]  in_kind;

    assign in_x     = s_tdata[31:0];
    assign in_y     = s_tdata[63:32];
    assign in_z     = s_tdata[95:64];
    assign in_sigma = s_tdata[119:96];
    assign in_eps   = s_tdata[143:120];
    assign in_ix    = s_tdata[153:144];
    assign in_iy    = s_tdata[163:154];
    assign in_iz    = s_tdata[173:164];
    assign in_kind  = s_tuser;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    ljgp_state_t state_reg, state_next;

    logic [30:0] cutoff_reg;
    logic [23:0] site_sigma_reg;
    logic [31:0] site_strength_reg;
    logic [23:0] spacing_x_reg, spacing_y_reg, spacing_z_reg;

    logic [CW-1:0] count_reg;
    logic          overflow_reg;
    logic [CW-1:0] idx_reg;
    logic [4:0]    step_reg;
    logic          is_load_reg;

    // query point and squared cutoff
    logic [33:0] px_reg, py_reg, pz_reg;
    logic [61:0] rc2_reg;

    // load staging
    logic [31:0] ld_x_reg, ld_y_reg, ld_z_reg;
    logic [24:0] sig_sum_reg;
    logic [39:0] isq_v_reg, isq_r_reg, isq_b_reg;

    // pair term datapath
    ljgp_entry_t        rd_reg;
    logic [31:0]        mx_reg, my_reg, mz_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [63:0]        r2_reg;
    logic [31:0]        s2_reg, st_reg;
    logic [63:0]        rem_reg;
    logic [20:0]        u_reg;
    logic [41:0]        uu_reg, ulo_reg, uhi_reg;
    logic [44:0]        q_reg;
    logic [43:0]        phh_reg;
    logic [44:0]        phl_reg;
    logic [45:0]        pll_reg;
    logic [57:0]        q2_reg, mag_reg;
    logic               neg_reg;
    logic [60:0]        p0_reg, p1_reg;
    logic signed [58:0] term_reg;

    // accumulator and result register
    logic signed [63:0] acc_reg;
    logic               sat_reg;
    logic               m_valid_reg;
    logic [63:0]        m_data_reg;
    logic               m_sat_reg, m_ovf_reg;

    // Atom table: one entry per stored atom, read into a register
    ljgp_entry_t mem [MAX_ATOMS];

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Clamp a grid index to the last grid point
    function automatic logic [9:0] idx_clamp(input logic [9:0] i);
        return (32'(i) > 32'(GRID_SIZE - 1)) ? 10'(GRID_SIZE - 1) : i;
    endfunction

    // |point - atom| along one axis, limited to 2^31
    function automatic logic [31:0] axis_mag(input logic [33:0] p, input logic [31:0] a);
        logic signed [35:0] d;
        logic [35:0]        m;
        d = $signed({2'b00, p}) - 36'($signed(a));
        m = d[35] ? 36'(-d) : 36'(d);
        return (m > 36'd2147483648) ? 32'h8000_0000 : m[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Combinational datapath pieces
    // ------------------------------------------------------------------
    logic        accept;
    logic        table_full;
    logic        atom_last;
    logic [63:0] r2_sum;
    logic        out_of_range;
    logic        term_capped;

    assign accept       = s_tvalid && s_tready;
    assign table_full   = (count_reg >= CW'(MAX_ATOMS));
    assign atom_last    = (idx_reg == count_reg - CW'(1));
    assign r2_sum       = sqx_reg + sqy_reg + sqz_reg;
    assign out_of_range = (cutoff_reg != 31'd0) && (r2_sum > 64'(rc2_reg));
    // Quotient of sigma^2 * 2^32 by r^2 does not fit 21 bits: take the cap
    assign term_capped  = (64'({s2_reg, 11'b0}) >= r2_reg);

    // divider step
    logic [64:0] div_rem2;
    logic        div_ge;
    assign div_rem2 = {rem_reg, 1'b0};
    assign div_ge   = (div_rem2 >= {1'b0, r2_reg});

    // square root step
    logic [39:0] isq_rb;
    logic        isq_ge;
    assign isq_rb = isq_r_reg + isq_b_reg;
    assign isq_ge = (isq_v_reg >= isq_rb);

    // mixed sigma^2 and strength
    logic [49:0] sig_sq_full;
    logic [51:0] str_full;
    logic [35:0] str_rnd;
    assign sig_sq_full = 50'(sig_sum_reg) * 50'(sig_sum_reg) + 50'(131072);
    assign str_full    = 52'(site_strength_reg) * 52'(isq_r_reg[19:0]) + 52'(32768);
    assign str_rnd     = str_full[51:16];

    // cap the ratio, then the cube
    logic [20:0] u_capped;
    logic [63:0] q_full;
    logic [62:0] q_capped;
    assign u_capped = (u_reg > U_CAP) ? U_CAP : u_reg;
    assign q_full   = {1'b0, uhi_reg, 21'b0} + 64'(ulo_reg);
    assign q_capped = (q_full > 64'(Q_MAX)) ? Q_MAX : q_full[62:0];

    // q^2 and strength product reassembly
    logic [89:0] q2_full, prod_full;
    logic [57:0] prod_hi;
    assign q2_full   = {phh_reg, 46'b0} + 90'({phl_reg, 24'b0}) + 90'(pll_reg);
    assign prod_full = 90'({p1_reg, 29'b0}) + 90'(p0_reg);
    assign prod_hi   = prod_full[89:32];

    // shift limited to 48 bits, entry to store
    logic signed [58:0] shift_clamped;
    ljgp_entry_t        wr_entry;
    assign shift_clamped = (term_reg > SHIFT_HI) ? SHIFT_HI :
                           (term_reg < SHIFT_LO) ? SHIFT_LO : term_reg;
    assign wr_entry = '{x: ld_x_reg, y: ld_y_reg, z: ld_z_reg, sigma_sq: s2_reg,
                        strength: st_reg, shift: shift_clamped[47:0]};

    // saturating accumulate
    logic signed [59:0] t_val;
    logic signed [64:0] acc_sum;
    logic signed [63:0] acc_new;
    logic               acc_hit;
    assign t_val   = 60'(term_reg) - 60'(rd_reg.shift);
    assign acc_sum = 65'(acc_reg) + 65'(t_val);
    always_comb begin
        acc_hit = 1'b0;
        acc_new = acc_sum[63:0];
        if (acc_sum[64:63] == 2'b01) begin
            acc_new = 64'sh7FFF_FFFF_FFFF_FFFF;
            acc_hit = 1'b1;
        end else if (acc_sum[64:63] == 2'b10) begin
            acc_new = 64'sh8000_0000_0000_0000;
            acc_hit = 1'b1;
        end
    end

    logic out_fire;
    assign out_fire = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (in_kind)
                        KIND_LOAD: begin
                            if (!table_full) state_next = ST_LD_SIG;
                        end
                        KIND_QUERY: begin
                            state_next = (count_reg == '0) ? ST_OUT : ST_Q_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LD_SIG:  state_next = ST_LD_ISQ;
            ST_LD_ISQ: begin
                if (step_reg == ISQ_STEPS - 5'd1) state_next = ST_LD_STR;
            end
            ST_LD_STR:  state_next = (cutoff_reg == 31'd0) ? ST_T_END : ST_T_START;
            ST_Q_RD:    state_next = ST_Q_DIST;
            ST_Q_DIST:  state_next = ST_Q_SQ;
            ST_Q_SQ:    state_next = ST_Q_SUM;
            ST_Q_SUM: begin
                if (!out_of_range) state_next = ST_T_START;
                else if (atom_last) state_next = ST_OUT;
                else state_next = ST_Q_RD;
            end
            ST_T_START: begin
                if (s2_reg == 32'd0) state_next = ST_T_END;
                else if (term_capped) state_next = ST_T_U2;
                else state_next = ST_T_DIV;
            end
            ST_T_DIV: begin
                if (step_reg == DIV_STEPS - 5'd1) state_next = ST_T_U2;
            end
            ST_T_U2:    state_next = ST_T_U3;
            ST_T_U3:    state_next = ST_T_Q;
            ST_T_Q:     state_next = ST_T_QQ;
            ST_T_QQ:    state_next = ST_T_Q2;
            ST_T_Q2:    state_next = ST_T_DIFF;
            ST_T_DIFF:  state_next = ST_T_ST;
            ST_T_ST:    state_next = ST_T_TERM;
            ST_T_TERM:  state_next = ST_T_END;
            ST_T_END: begin
                if (is_load_reg) state_next = ST_IDLE;
                else if (atom_last) state_next = ST_OUT;
                else state_next = ST_Q_RD;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration, table bookkeeping and result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cutoff_reg        <= '0;
            site_sigma_reg    <= '0;
            site_strength_reg <= '0;
            spacing_x_reg     <= 24'd65536;
            spacing_y_reg     <= 24'd65536;
            spacing_z_reg     <= 24'd65536;
            count_reg         <= '0;
            overflow_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_CUTOFF:    cutoff_reg        <= cfg_wdata[30:0];
                    REG_SIGMA:     site_sigma_reg    <= cfg_wdata[23:0];
                    REG_STRENGTH:  site_strength_reg <= cfg_wdata;
                    REG_SPACING_X: spacing_x_reg     <= cfg_wdata[23:0];
                    REG_SPACING_Y: spacing_y_reg     <= cfg_wdata[23:0];
                    REG_SPACING_Z: spacing_z_reg     <= cfg_wdata[23:0];
                    default: ;
                endcase
            end

            // drop a load into a full table and remember it until a clear
            if (accept && in_kind == KIND_LOAD && table_full) overflow_reg <= 1'b1;
            if (accept && in_kind == KIND_CLEAR) begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            if (state_reg == ST_T_END && is_load_reg) count_reg <= count_reg + CW'(1);

            // hold a result until taken; refill in the same cycle it leaves
            if (out_fire) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    is_load_reg <= (in_kind == KIND_LOAD);
                    rc2_reg     <= 62'(cutoff_reg) * 62'(cutoff_reg);
                    // load staging
                    ld_x_reg    <= in_x;
                    ld_y_reg    <= in_y;
                    ld_z_reg    <= in_z;
                    sig_sum_reg <= 25'(site_sigma_reg) + 25'(in_sigma);
                    isq_v_reg   <= {in_eps, 16'b0};
                    isq_r_reg   <= '0;
                    isq_b_reg   <= 40'h40_0000_0000;
                    step_reg    <= '0;
                    // query setup
                    px_reg      <= 34'(idx_clamp(in_ix)) * 34'(spacing_x_reg);
                    py_reg      <= 34'(idx_clamp(in_iy)) * 34'(spacing_y_reg);
                    pz_reg      <= 34'(idx_clamp(in_iz)) * 34'(spacing_z_reg);
                    idx_reg     <= '0;
                    acc_reg     <= '0;
                    sat_reg     <= 1'b0;
                end
            end
            ST_LD_SIG: begin
                s2_reg <= sig_sq_full[49:18];
            end
            ST_LD_ISQ: begin
                if (isq_ge) begin
                    isq_v_reg <= isq_v_reg - isq_rb;
                    isq_r_reg <= (isq_r_reg >> 1) + isq_b_reg;
                end else begin
                    isq_r_reg <= isq_r_reg >> 1;
                end
                isq_b_reg <= isq_b_reg >> 2;
                step_reg  <= step_reg + 5'd1;
            end
            ST_LD_STR: begin
                st_reg   <= (str_rnd > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : str_rnd[31:0];
                r2_reg   <= 64'(rc2_reg);
                term_reg <= '0;
            end
            ST_Q_DIST: begin
                mx_reg <= axis_mag(px_reg, rd_reg.x);
                my_reg <= axis_mag(py_reg, rd_reg.y);
                mz_reg <= axis_mag(pz_reg, rd_reg.z);
            end
            ST_Q_SQ: begin
                sqx_reg <= 64'(mx_reg) * 64'(mx_reg);
                sqy_reg <= 64'(my_reg) * 64'(my_reg);
                sqz_reg <= 64'(mz_reg) * 64'(mz_reg);
            end
            ST_Q_SUM: begin
                r2_reg <= r2_sum;
                s2_reg <= rd_reg.sigma_sq;
                st_reg <= rd_reg.strength;
                if (out_of_range) idx_reg <= idx_reg + CW'(1);
            end
            ST_T_START: begin
                term_reg <= '0;
                u_reg    <= U_CAP;
                rem_reg  <= 64'({s2_reg, 11'b0});
                step_reg <= '0;
            end
            ST_T_DIV: begin
                rem_reg  <= div_ge ? 64'(div_rem2 - {1'b0, r2_reg}) : div_rem2[63:0];
                u_reg    <= {u_reg[19:0], div_ge};
                step_reg <= step_reg + 5'd1;
            end
            ST_T_U2: begin
                u_reg  <= u_capped;
                uu_reg <= 42'(u_capped) * 42'(u_capped);
            end
            ST_T_U3: begin
                ulo_reg <= 42'(uu_reg[20:0]) * 42'(u_reg);
                uhi_reg <= 42'(uu_reg[41:21]) * 42'(u_reg);
            end
            ST_T_Q: begin
                q_reg <= q_capped[60:16];
            end
            ST_T_QQ: begin
                phh_reg <= 44'(q_reg[44:23]) * 44'(q_reg[44:23]);
                phl_reg <= 45'(q_reg[44:23]) * 45'(q_reg[22:0]);
                pll_reg <= 46'(q_reg[22:0]) * 46'(q_reg[22:0]);
            end
            ST_T_Q2: begin
                q2_reg <= q2_full[89:32];
            end
            ST_T_DIFF: begin
                neg_reg <= (q2_reg < 58'(q_reg));
                mag_reg <= (q2_reg < 58'(q_reg)) ? 58'(q_reg) - q2_reg : q2_reg - 58'(q_reg);
            end
            ST_T_ST: begin
                p0_reg <= 61'(st_reg) * 61'(mag_reg[28:0]);
                p1_reg <= 61'(st_reg) * 61'(mag_reg[57:29]);
            end
            ST_T_TERM: begin
                term_reg <= neg_reg ? -$signed({1'b0, prod_hi}) : $signed({1'b0, prod_hi});
            end
            ST_T_END: begin
                if (!is_load_reg) begin
                    acc_reg <= acc_new;
                    if (acc_hit) sat_reg <= 1'b1;
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            ST_OUT: begin
                if (out_fire) begin
                    m_data_reg <= acc_reg;
                    m_sat_reg  <= sat_reg;
                    m_ovf_reg  <= overflow_reg;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Atom table
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (state_reg == ST_T_END && is_load_reg) mem[count_reg[AW-1:0]] <= wr_entry;
        if (state_reg == ST_Q_RD) rd_reg <= mem[idx_reg[AW-1:0]];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_ovf_reg, m_sat_reg};

endmodule

/* hw/rtl/ljgp_checker.sv */
// ----------------------------------------------------------------------------
// ljgp_checker
// Port-level checks of the grid Lennard-Jones potential core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ljgp_checker
    import ljgp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A query occupies the core: no beat is taken in the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == KIND_QUERY |=> !s_tready)
        else $error("input taken right after a query");

endmodule

bind lennard_jones_grid_potential_core ljgp_checker u_ljgp_checker (.*);
